/* rtl/lcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types, codes and constants of the lidar costmap inflation unit.
// ----------------------------------------------------------------------------
package lcm_pkg;

    // Default grid edge length in cells
    localparam int GRID_EDGE_DEF = 100;

    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_START = 19899;
    localparam int COST_W       = 7;
    localparam int KBITS        = 7;
    localparam logic [COST_W-1:0] HIT_COST  = 7'd100;
    localparam logic [COST_W-1:0] COST_CLIP = 7'd100;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ANGLE_START = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_MAX_RANGE   = 3'd2,
        REG_CENTER_OFFS = 3'd3,
        REG_CELLS_PER_M = 3'd4,
        REG_INFL_RADIUS = 3'd5,
        REG_MAX_COST    = 3'd6
    } t_reg_idx;

    // Item commands
    typedef enum logic {
        CMD_RETURN = 1'b0,
        CMD_READ   = 1'b1
    } t_command;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_RANGE   = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    typedef struct packed {
        logic        command;
        logic [15:0] range_q8;
        logic [11:0] beam_index;
        logic [7:0]  read_col;
        logic [7:0]  read_row;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        hit_col;
        logic [7:0]        hit_row;
        logic [COST_W-1:0] cell_cost;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    ang_en;
        logic    cordic_init;
        logic    cordic_step;
        logic    mul_a;
        logic    mul_b;
        logic    mul_c;
        logic    hit_wr;
        logic    scan_start;
        logic    scan_step;
        logic    rd_issue;
        logic    rd_capture;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic beyond;
        logic cordic_last;
        logic in_grid;
        logic scan_last;
        logic pipe_busy;
    } t_sts;

    // atan(2^-i) in binary angle units
    function automatic logic [13:0] step_angle(input logic [3:0] idx);
        logic [13:0] a;
        unique case (idx)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

/* rtl/lcm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcm_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/lcm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_dp
// Datapath: configuration registers, CORDIC, cell mapping, inflation
// pipeline and cost grid memory.
// ----------------------------------------------------------------------------
module lcm_dp
    import lcm_pkg::*;
#(
    parameter int GRID_EDGE = GRID_EDGE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output t_out_item      o_out_data
);

    localparam int DEPTH = GRID_EDGE * GRID_EDGE;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers
    logic [15:0]       r_ang_start, r_ang_step, r_max_range, r_offset, r_cpm;
    logic [4:0]        r_radius;
    logic [COST_W-1:0] r_max_cost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_start <= 16'd0;
            r_ang_step  <= 16'd0;
            r_max_range <= 16'd12800;
            r_offset    <= 16'd1280;
            r_cpm       <= 16'd2560;
            r_radius    <= 5'd10;
            r_max_cost  <= 7'd100;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ANGLE_START: r_ang_start <= i_cfg_data;
                REG_ANGLE_STEP:  r_ang_step  <= i_cfg_data;
                REG_MAX_RANGE:   r_max_range <= i_cfg_data;
                REG_CENTER_OFFS: r_offset    <= i_cfg_data;
                REG_CELLS_PER_M: r_cpm       <= i_cfg_data;
                REG_INFL_RADIUS: r_radius    <= i_cfg_data[4:0];
                REG_MAX_COST:    r_max_cost  <= i_cfg_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // Item capture, beam angle and cost scale
    t_in_item    r_item;
    logic [15:0] r_ang;
    logic [13:0] r_mc2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.ang_en) begin
            r_ang <= r_ang_start + 16'(r_item.beam_index * r_ang_step);
            r_mc2 <= 14'(r_max_cost) * 14'(r_max_cost);
        end
    end

    // CORDIC, one rotation per cycle
    logic signed [17:0] r_cx, r_cy, r_cz;
    logic [3:0]         r_iter;
    logic               r_flip;
    logic [15:0]        fold_ang;
    logic signed [17:0] dx, dy, step_a;

    assign fold_ang = {r_ang[15] ^ (r_ang[15] ^ r_ang[14]), r_ang[14:0]};
    assign dx       = r_cy >>> r_iter;
    assign dy       = r_cx >>> r_iter;
    assign step_a   = signed'({4'd0, step_angle(r_iter)});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_cx   <= 18'sd19899;
            r_cy   <= 18'sd0;
            r_cz   <= signed'({{2{fold_ang[15]}}, fold_ang});
            r_iter <= 4'd0;
            r_flip <= r_ang[15] ^ r_ang[14];
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[17]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - step_a;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + step_a;
            end
            r_iter <= r_iter + 4'd1;
        end
    end

    // Map to cells: range times trig plus offset, then scale in two halves
    logic signed [17:0] cos_v, sin_v;
    logic signed [16:0] s_range;
    logic signed [34:0] px, py, offs;
    logic signed [34:0] r_vx, r_vy;
    logic [34:0]        mag_x, mag_y;
    logic [32:0]        r_plo_x, r_phi_x, r_plo_y, r_phi_y;
    logic               r_neg_x, r_neg_y;
    logic [49:0]        m_x, m_y;
    logic [18:0]        r_qx, r_qy;

    assign cos_v   = r_flip ? -r_cx : r_cx;
    assign sin_v   = r_flip ? -r_cy : r_cy;
    assign s_range = signed'({1'b0, r_item.range_q8});
    assign px      = s_range * cos_v;
    assign py      = s_range * sin_v;
    assign offs    = signed'({4'd0, r_offset, 15'd0});
    assign mag_x   = r_vx[34] ? unsigned'(-r_vx) : unsigned'(r_vx);
    assign mag_y   = r_vy[34] ? unsigned'(-r_vy) : unsigned'(r_vy);
    assign m_x     = {r_phi_x, 17'd0} + {17'd0, r_plo_x};
    assign m_y     = {r_phi_y, 17'd0} + {17'd0, r_plo_y};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_vx <= px + offs;
            r_vy <= py + offs;
        end
        if (i_cmd.mul_b) begin
            r_neg_x <= r_vx[34];
            r_neg_y <= r_vy[34];
            r_plo_x <= mag_x[16:0] * r_cpm;
            r_phi_x <= mag_x[33:17] * r_cpm;
            r_plo_y <= mag_y[16:0] * r_cpm;
            r_phi_y <= mag_y[33:17] * r_cpm;
        end
        if (i_cmd.mul_c) begin
            r_qx <= m_x[49:31];
            r_qy <= m_y[49:31];
        end
    end

    logic          ok_x, ok_y;
    logic [7:0]    hit_col, hit_row;
    logic [AW-1:0] hit_addr;

    // Negative values that truncate to zero still land on cell zero
    assign ok_x     = (r_qx == 19'd0) || (!r_neg_x && (r_qx < 19'(GRID_EDGE)));
    assign ok_y     = (r_qy == 19'd0) || (!r_neg_y && (r_qy < 19'(GRID_EDGE)));
    assign hit_col  = r_qx[7:0];
    assign hit_row  = r_qy[7:0];
    assign hit_addr = AW'(32'(hit_row) * GRID_EDGE + 32'(hit_col));

    // Neighborhood scan generator
    logic signed [5:0]  r_dr, r_dc;
    logic [4:0]         lim;
    logic signed [5:0]  s_lim;
    logic signed [11:0] sq_r, sq_c;
    logic [10:0]        d2;
    logic [9:0]         r2;
    logic signed [9:0]  cr, cc;
    logic               ok_r, ok_c, s0_v;
    logic [AW-1:0]      s0_a;

    assign lim   = (r_radius == 5'd0) ? 5'd0 : r_radius - 5'd1;
    assign s_lim = signed'({1'b0, lim});
    assign sq_r  = r_dr * r_dr;
    assign sq_c  = r_dc * r_dc;
    assign d2    = 11'(sq_r + sq_c);
    assign r2    = 10'(r_radius) * 10'(r_radius);
    assign cr    = signed'({2'd0, hit_row}) + {{4{r_dr[5]}}, r_dr};
    assign cc    = signed'({2'd0, hit_col}) + {{4{r_dc[5]}}, r_dc};
    assign ok_r  = !cr[9] && (cr[8:0] < 9'(GRID_EDGE));
    assign ok_c  = !cc[9] && (cc[8:0] < 9'(GRID_EDGE));
    assign s0_v  = i_cmd.scan_step && (d2 != 11'd0) && ({1'b0, d2} < {1'b0, r2})
                   && ok_r && ok_c;
    assign s0_a  = AW'(32'(cr[8:0]) * GRID_EDGE + 32'(cc[8:0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_dr <= -s_lim;
            r_dc <= -s_lim;
        end else if (i_cmd.scan_step) begin
            if (r_dc == s_lim) begin
                r_dc <= -s_lim;
                r_dr <= r_dr + 6'sd1;
            end else begin
                r_dc <= r_dc + 6'sd1;
            end
        end
    end

    // Cost pipeline: squared bound, then a bitwise search for k
    logic          r_s0_v, r_t_v;
    logic [AW-1:0] r_s0_a, r_t_a;
    logic [10:0]   r_s0_d2;
    logic [24:0]   r_t_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_t_v  <= 1'b0;
        end else begin
            r_s0_v <= s0_v;
            r_t_v  <= r_s0_v;
        end
        r_s0_a  <= s0_a;
        r_s0_d2 <= d2;
        r_t_a   <= r_s0_a;
        r_t_t   <= 25'(r_mc2) * 25'(r_s0_d2);
    end

    logic              ra_v [KBITS];
    logic              rb_v [KBITS];
    logic [AW-1:0]     ra_a [KBITS];
    logic [AW-1:0]     rb_a [KBITS];
    logic [24:0]       ra_t [KBITS];
    logic [24:0]       rb_t [KBITS];
    logic [KBITS-1:0]  ra_g [KBITS];
    logic [KBITS-1:0]  rb_g [KBITS];
    logic [11:0]       ra_kr [KBITS];

    for (genvar j = 0; j < KBITS; j++) begin : g_bit
        localparam logic [KBITS-1:0] BIT = KBITS'(1) << (KBITS - 1 - j);
        logic             in_v;
        logic [AW-1:0]    in_a;
        logic [24:0]      in_t;
        logic [KBITS-1:0] in_g, cand_a, cand_b;
        logic [23:0]      sq;

        if (j == 0) begin : g_first
            assign in_v = r_t_v;
            assign in_a = r_t_a;
            assign in_t = r_t_t;
            assign in_g = '0;
        end else begin : g_next
            assign in_v = rb_v[j-1];
            assign in_a = rb_a[j-1];
            assign in_t = rb_t[j-1];
            assign in_g = rb_g[j-1];
        end

        assign cand_a = in_g | BIT;
        assign cand_b = ra_g[j] | BIT;
        assign sq     = ra_kr[j] * ra_kr[j];

        // Keep the candidate bit while its square stays below the bound
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ra_v[j] <= 1'b0;
                rb_v[j] <= 1'b0;
            end else begin
                ra_v[j] <= in_v;
                rb_v[j] <= ra_v[j];
            end
            ra_a[j]  <= in_a;
            ra_t[j]  <= in_t;
            ra_g[j]  <= in_g;
            ra_kr[j] <= 12'(cand_a) * 12'(r_radius);
            rb_a[j]  <= ra_a[j];
            rb_t[j]  <= ra_t[j];
            rb_g[j]  <= ({1'b0, sq} < ra_t[j]) ? cand_b : ra_g[j];
        end
    end

    logic [7:0]        k_val;
    logic [COST_W-1:0] infl_cost;
    logic              r_w_v;
    logic [AW-1:0]     r_w_a;
    logic [COST_W-1:0] r_w_cost;

    assign k_val     = (rb_t[KBITS-1] == 25'd0) ? 8'd0 : {1'b0, rb_g[KBITS-1]} + 8'd1;
    assign infl_cost = 7'({1'b0, r_max_cost} - k_val);

    // Read-modify-write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else begin
            r_w_v <= rb_v[KBITS-1];
        end
        r_w_a    <= rb_a[KBITS-1];
        r_w_cost <= infl_cost;
    end

    // Grid memory and port selection
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr, rd_addr, r_clr;
    logic [COST_W-1:0] ram_wdata, ram_rdata;
    logic              infl_wr, rd_in_grid;

    assign rd_in_grid = (r_item.read_col < 8'(GRID_EDGE - 1) + 8'd1 || GRID_EDGE == 256)
                        && (r_item.read_row < 8'(GRID_EDGE - 1) + 8'd1 || GRID_EDGE == 256);
    assign rd_addr    = AW'(32'(r_item.read_row) * GRID_EDGE + 32'(r_item.read_col));
    assign infl_wr    = r_w_v && (r_w_cost > ram_rdata);
    assign ram_raddr  = i_cmd.rd_issue ? rd_addr : rb_a[KBITS-1];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_w_a;
        ram_wdata = r_w_cost;
        priority if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (i_cmd.hit_wr) begin
            ram_we    = 1'b1;
            ram_waddr = hit_addr;
            ram_wdata = HIT_COST;
        end else if (infl_wr) begin
            ram_we = 1'b1;
        end
    end

    lcm_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Read result and output register
    logic [COST_W-1:0] r_rd_cost;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_capture) begin
            if (!rd_in_grid) begin
                r_rd_cost <= '0;
            end else if (ram_rdata > COST_CLIP) begin
                r_rd_cost <= COST_CLIP;
            end else begin
                r_rd_cost <= ram_rdata;
            end
        end
        if (i_cmd.out_load) begin
            o_out_data.status    <= i_cmd.out_status;
            o_out_data.hit_col   <= (i_cmd.out_status == ST_HIT) ? hit_col : 8'd0;
            o_out_data.hit_row   <= (i_cmd.out_status == ST_HIT) ? hit_row : 8'd0;
            o_out_data.cell_cost <= (i_cmd.out_status == ST_READ) ? r_rd_cost : '0;
        end
    end

    // Status back to the controller
    logic busy;

    always_comb begin
        busy = r_s0_v | r_t_v | r_w_v;
        for (int j = 0; j < KBITS; j++) begin
            busy = busy | ra_v[j] | rb_v[j];
        end
    end

    assign o_sts.clr_last    = (r_clr == AW'(DEPTH - 1));
    assign o_sts.is_read     = (r_item.command == CMD_READ);
    assign o_sts.beyond      = (r_item.range_q8 > r_max_range);
    assign o_sts.cordic_last = (r_iter == 4'(CORDIC_STEPS - 1));
    assign o_sts.in_grid     = ok_x && ok_y;
    assign o_sts.scan_last   = (r_dr == s_lim) && (r_dc == s_lim);
    assign o_sts.pipe_busy   = busy;

    // Inflation never rewrites the hit cell
    a_no_hit_rewrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_v |-> (r_w_a != hit_addr))
        else $error("inflation write targets hit cell");

    // Inflated cost stays below the scale
    a_cost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_v |-> ((r_w_cost < r_max_cost) || (r_w_cost == '0)))
        else $error("inflated cost out of bound");

    // Clearing never overlaps the cost pipeline
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !busy)
        else $error("clear write during inflation");

endmodule
`default_nettype wire

/* rtl/lcm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_ctrl
// Controller: sequences clearing, mapping, inflation, reads and results.
// ----------------------------------------------------------------------------
module lcm_ctrl
    import lcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_READ, S_READ_WAIT, S_FOLD, S_CORDIC,
        S_MUL1, S_MUL2, S_MUL3, S_HIT, S_SCAN, S_DRAIN, S_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd      = '0;
        o_cmd.out_status = r_code;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.ang_en = 1'b1;
                priority if (i_sts.is_read) begin
                    n_state = S_READ;
                end else if (i_sts.beyond) begin
                    n_code  = ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_code           = ST_READ;
                n_state          = S_DONE;
            end
            S_FOLD: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_sts.cordic_last) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_c = 1'b1;
                n_state     = S_HIT;
            end
            S_HIT: begin
                if (i_sts.in_grid) begin
                    o_cmd.hit_wr     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_code           = ST_HIT;
                    n_state          = S_SCAN;
                end else begin
                    n_code  = ST_OUTSIDE;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result valid until its transfer
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_code      <= ST_HIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result appears only from the final state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside final state");

    // No inflation work outstanding while waiting for an item
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pipe_busy)
        else $error("pipeline busy in idle");

    // A miss reports outside-grid status
    a_miss_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HIT && !i_sts.in_grid) |=> (r_code == ST_OUTSIDE))
        else $error("miss status lost");

endmodule
`default_nettype wire

/* rtl/lidar_costmap_inflation_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_costmap_inflation_unit
// Lidar return to costmap cell with circular obstacle inflation, plus reads.
//
//   Channel  Direction  Handshake                Payload
//   in       input      i_in_valid / o_in_ready  i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
//   cfg      input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// Hit: (2r-1)^2 neighbor cells are scanned, one per cycle, through the
// single read/write port pair of the grid memory. After reset a clearing
// pass over all GRID_EDGE*GRID_EDGE cells runs before the first item is
// taken. A stalled result is held in the output register while the next
// item is taken; it finishes only once that register is free.
// ----------------------------------------------------------------------------
module lidar_costmap_inflation_unit
    import lcm_pkg::*;
#(
    parameter int GRID_EDGE = GRID_EDGE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    lcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic, pipeline and grid
    lcm_dp #(
        .GRID_EDGE (GRID_EDGE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
